// ----- sv/hmp_pkg.sv -----
package hmp_pkg;

    // Field widths
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + 4;
    localparam int RES_W  = 32;
    localparam int DIM_W  = 4;
    localparam int OP_W   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    // Smallest dimension honored
    localparam logic [DIM_W-1:0] DIM_MIN   = 4'd3;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Control that travels down the multiply-accumulate pipe with each term
    typedef struct packed {
        logic vld;   // a term is in this stage
        logic ok;    // term lies inside both bands
        logic last;  // final term of the current product element
    } mac_ctl_t;

endpackage

// ----- sv/hmp_ram.sv -----
module hmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/hmp_mac.sv -----
module hmp_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  hmp_pkg::mac_ctl_t                    s1_ctl,
    input  logic signed [hmp_pkg::VAL_W-1:0]     a_data,
    input  logic signed [hmp_pkg::VAL_W-1:0]     b_data,
    output logic                                 done,
    output logic signed [hmp_pkg::RES_W-1:0]     sum_sat
);
    import hmp_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'({1'b0, {(RES_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        -ACC_W'({1'b1, {(RES_W-1){1'b0}}});

    mac_ctl_t                   s2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    sum_full;

    // Stage 2: one Q8.8 x Q8.8 multiply, exact in Q16.16
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg <= '0;
        end else begin
            s2_reg <= s1_ctl;
        end
        prod_reg <= a_data * b_data;
    end

    // Out-of-band terms count as zero
    assign term     = s2_reg.ok ? ACC_W'(prod_reg) : '0;
    assign sum_full = acc_reg + term;

    // Stage 3: accumulate; clear after the final term of an element
    always_comb begin
        acc_next = acc_reg;
        if (s2_reg.vld) begin
            acc_next = s2_reg.last ? '0 : sum_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // Saturate the exact sum to 32 bits
    always_comb begin
        if (sum_full > SAT_MAX) begin
            sum_sat = RES_W'(SAT_MAX);
        end else if (sum_full < SAT_MIN) begin
            sum_sat = RES_W'(SAT_MIN);
        end else begin
            sum_sat = RES_W'(sum_full);
        end
    end

    assign done = s2_reg.vld && s2_reg.last;

    property p_acc_clear_after_done;
        @(posedge aclk) disable iff (!aresetn)
        done |=> (acc_reg == '0);
    endproperty
    a_acc_clear_after_done: assert property (p_acc_clear_after_done)
        else $error("accumulator not cleared after final term");

    property p_stage_follows;
        @(posedge aclk) disable iff (!aresetn)
        s1_ctl.vld |=> s2_reg.vld;
    endproperty
    a_stage_follows: assert property (p_stage_follows)
        else $error("term lost between stages");

    property p_sat_range;
        @(posedge aclk) disable iff (!aresetn)
        done && (sum_full > SAT_MAX) |-> (sum_sat == RES_W'(SAT_MAX));
    endproperty
    a_sat_range: assert property (p_sat_range)
        else $error("positive saturation wrong");

endmodule

// ----- sv/hessenberg_matrix_product_top.sv -----
// Upper Hessenberg matrix product, Q8.8 in, Q16.16 out.
// Input channel (s_*): one beat per operation. Load A / load B beats write
// one band element (col <= row + 1, row and col below n) into the A or B
// store; other loads and unused operation codes are dropped. A start beat
// computes C = A * B for the current dimension n.
// Result channel (m_*): n*n beats in row-major order, last_flag on C[n-1][n-1].
// Config channel (cfg_*): writes dim_in_use; values below 3 act as 3,
// values above MAX_DIM act as MAX_DIM. Write only while the block is idle.
// Sequence: after a start, one shared multiplier and accumulator step through
// k = 0..n-1 for each element, then the block waits while the multiply and
// accumulate stages drain. s_ready stays low from the start beat until the
// last element is in the output register.
// Stall: the next element is not begun until the output register is free
// or being taken, so a stalled receiver simply holds the sequencer.
// Reset: dimension returns to 8, control clears; store contents are
// undefined until written.
module hessenberg_matrix_product_top #(
    parameter int MAX_DIM = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hmp_pkg::DIM_W-1:0]           cfg_data,
    // input beats
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [hmp_pkg::OP_W-1:0]            s_operation,
    input  logic [hmp_pkg::IDX_W-1:0]           s_row_index,
    input  logic [hmp_pkg::IDX_W-1:0]           s_col_index,
    input  logic signed [hmp_pkg::VAL_W-1:0]    s_element_value,
    // result beats
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hmp_pkg::IDX_W-1:0]           m_out_row,
    output logic [hmp_pkg::IDX_W-1:0]           m_out_col,
    output logic signed [hmp_pkg::RES_W-1:0]    m_product_value,
    output logic                                m_last_flag
);
    import hmp_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [DIM_W-1:0]    dim_in_use_reg;
    logic [DIM_W-1:0]    n_act;
    logic [DIM_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [DIM_W-1:0]    n_m1;
    logic                k_end, j_end, i_end;

    logic                s_acc;
    logic                ld_ok;
    logic                we_a, we_b;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   raddr_a, raddr_b;
    logic [VAL_W-1:0]    rd_a, rd_b;

    logic                out_free;
    logic                issue;
    logic                band_ok;
    mac_ctl_t            s1_reg;
    logic                mac_done;
    logic signed [RES_W-1:0] mac_sum;

    logic                m_valid_reg;
    logic [IDX_W-1:0]    m_row_reg, m_col_reg;
    logic signed [RES_W-1:0] m_val_reg;
    logic                m_last_reg;

    // Config register, clamped to the supported range
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_in_use_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            dim_in_use_reg <= cfg_data;
        end
    end

    always_comb begin
        if (dim_in_use_reg < DIM_MIN) begin
            n_act = DIM_MIN;
        end else if (dim_in_use_reg > DIM_MAX) begin
            n_act = DIM_MAX;
        end else begin
            n_act = dim_in_use_reg;
        end
    end

    // Load path: band elements inside the matrix only
    assign s_ready = (state_reg == S_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign ld_ok   = ({1'b0, s_row_index} < n_act) && ({1'b0, s_col_index} < n_act)
                     && ({1'b0, s_col_index} <= ({1'b0, s_row_index} + 4'd1));
    assign we_a    = s_acc && ld_ok && (s_operation == OP_LOAD_A);
    assign we_b    = s_acc && ld_ok && (s_operation == OP_LOAD_B);
    assign waddr   = ADDR_W'(int'(s_row_index) * MAX_DIM + int'(s_col_index));

    // Read addresses for term A[i][k] * B[k][j]
    assign raddr_a = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign raddr_b = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

    hmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_a (
        .clk   (aclk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (s_element_value),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    hmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_b (
        .clk   (aclk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (s_element_value),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    // Sequencer
    assign out_free = !m_valid_reg || m_ready;
    assign n_m1     = n_reg - 4'd1;
    assign k_end    = ({1'b0, k_reg} == n_m1);
    assign j_end    = ({1'b0, j_reg} == n_m1);
    assign i_end    = ({1'b0, i_reg} == n_m1);
    assign issue    = (state_reg == S_ISSUE) && ((k_reg != '0) || out_free);
    assign band_ok  = ({1'b0, k_reg} <= ({1'b0, i_reg} + 4'd1))
                      && ({1'b0, j_reg} <= ({1'b0, k_reg} + 4'd1));

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc && (s_operation == OP_START)) begin
                    n_next     = n_act;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (issue) begin
                    if (k_end) begin
                        k_next     = '0;
                        state_next = S_DRAIN;
                    end else begin
                        k_next = k_reg + 3'd1;
                    end
                end
            end
            S_DRAIN: begin
                if (mac_done) begin
                    if (j_end) begin
                        j_next = '0;
                        i_next = i_reg + 3'd1;
                    end else begin
                        j_next = j_reg + 3'd1;
                    end
                    state_next = (i_end && j_end) ? S_IDLE : S_ISSUE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            n_reg     <= DIM_RESET;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            s1_reg    <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            s1_reg    <= '{vld: issue, ok: band_ok, last: k_end};
        end
    end

    hmp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s1_ctl  (s1_reg),
        .a_data  (rd_a),
        .b_data  (rd_b),
        .done    (mac_done),
        .sum_sat (mac_sum)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (mac_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (mac_done) begin
            m_row_reg  <= i_reg;
            m_col_reg  <= j_reg;
            m_val_reg  <= mac_sum;
            m_last_reg <= i_end && j_end;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_row       = m_row_reg;
    assign m_out_col       = m_col_reg;
    assign m_product_value = m_val_reg;
    assign m_last_flag     = m_last_reg;

    property p_done_in_drain;
        @(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == S_DRAIN);
    endproperty
    a_done_in_drain: assert property (p_done_in_drain)
        else $error("element finished outside drain");

    property p_no_overwrite;
        @(posedge aclk) disable iff (!aresetn)
        mac_done |-> !m_valid_reg;
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("output register overwritten");

    property p_last_on_diag;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_flag |-> (m_out_row == m_out_col);
    endproperty
    a_last_on_diag: assert property (p_last_on_diag)
        else $error("last flag off the final element");

    property p_issue_only_running;
        @(posedge aclk) disable iff (!aresetn)
        issue |-> !s_ready;
    endproperty
    a_issue_only_running: assert property (p_issue_only_running)
        else $error("term issued while accepting beats");

endmodule
